>>> hdl/hbcm_pkg.sv
// shared types, codes and constants of the heartbeat consumer monitor
package hbcm_pkg;

  // node numbering and table geometry
  localparam int NODE_W       = 7;
  localparam int IDX_W        = 6;
  localparam int DEPTH        = 64;
  localparam int MAX_NODE_DEF = 63;

  // field widths
  localparam int ST_W     = 8;
  localparam int HB_W     = 16;
  localparam int CD_W     = 26;
  localparam int PERIOD_W = 16;
  localparam int CNT_W    = 5;

  // operation codes
  localparam logic [1:0] OP_FRAME = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_SET   = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_BOOT = 2'd0;
  localparam logic [1:0] KIND_WARN = 2'd1;
  localparam logic [1:0] KIND_SET  = 2'd2;
  localparam logic [1:0] KIND_READ = 2'd3;

  // node state codes
  localparam logic [ST_W-1:0] ST_BOOT        = 8'd0;
  localparam logic [ST_W-1:0] ST_OPERATIONAL = 8'd5;
  localparam logic [ST_W-1:0] ST_UNCERTAIN   = 8'd128;
  localparam logic [ST_W-1:0] ST_UNKNOWN     = 8'd255;

  // frame identifier base, upper three bits of 0x700
  localparam logic [2:0] HB_ID_BASE_HI = 3'b111;

  // countdown arithmetic
  localparam logic [CD_W-1:0] CD_ONES   = '1;
  localparam logic [9:0]      US_PER_MS = 10'd1000;
  localparam logic [CNT_W-1:0] DIV_STEPS = 5'd26;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1000;

  // one table entry
  typedef struct packed {
    logic [ST_W-1:0] state;
    logic [HB_W-1:0] hb;
    logic [CD_W-1:0] cd;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // one result item
  typedef struct packed {
    logic [1:0]        kind;
    logic [NODE_W-1:0] node;
    logic [ST_W-1:0]   state;
    logic [HB_W-1:0]   ms;
    logic              error;
    logic              last;
  } res_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_DIV,
    S_WB,
    S_EMIT,
    S_TRD,
    S_TMOD,
    S_TEND
  } fsm_t;

  // contents of an entry that was never written
  function automatic entry_t entry_reset(input logic [IDX_W-1:0] idx);
    entry_t e;
    e.state = (idx == '0) ? ST_OPERATIONAL : ST_UNKNOWN;
    e.hb    = '0;
    e.cd    = '0;
    return e;
  endfunction

endpackage

>>> hdl/hbcm_ram.sv
// generic single write, single read port ram with registered read
module hbcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/hbcm_reload.sv
// countdown reload unit: 1 + ms * 1000 / period, one quotient bit per cycle
module hbcm_reload (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [hbcm_pkg::HB_W-1:0]     ms,
  input  logic [hbcm_pkg::PERIOD_W-1:0] period,
  output logic                         done,
  output logic [hbcm_pkg::CD_W-1:0]     value
);

  logic [hbcm_pkg::CD_W-1:0]     dvd;
  logic [hbcm_pkg::PERIOD_W-1:0] rem;
  logic [hbcm_pkg::PERIOD_W-1:0] divisor;
  logic [hbcm_pkg::CNT_W-1:0]    cnt;
  logic [hbcm_pkg::PERIOD_W:0]   trial;
  logic [hbcm_pkg::PERIOD_W:0]   diff;
  logic                          ge;

  // one restoring step
  always_comb begin
    trial = {rem, dvd[hbcm_pkg::CD_W-1]};
    diff  = trial - {1'b0, divisor};
    ge    = (trial >= {1'b0, divisor});
  end

  // step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == hbcm_pkg::CNT_W'(1));
      if (start) begin
        cnt <= hbcm_pkg::DIV_STEPS;
      end else if (cnt != '0) begin
        cnt <= cnt - hbcm_pkg::CNT_W'(1);
      end
    end
  end

  // product load, then shift quotient bits in
  always_ff @(posedge clk) begin
    if (start) begin
      dvd     <= hbcm_pkg::CD_W'(ms) * hbcm_pkg::CD_W'(hbcm_pkg::US_PER_MS);
      rem     <= '0;
      divisor <= (period == '0) ? hbcm_pkg::PERIOD_W'(1) : period;
    end else if (cnt != '0) begin
      dvd <= {dvd[hbcm_pkg::CD_W-2:0], ge};
      rem <= ge ? diff[hbcm_pkg::PERIOD_W-1:0] : trial[hbcm_pkg::PERIOD_W-1:0];
    end
  end

  assign value = dvd + hbcm_pkg::CD_W'(1);

endmodule

>>> hdl/hbcm_ctrl.sv
// sequencer: table read-modify-write, tick scan and result register
module hbcm_ctrl #(
  parameter int MAX_NODE = hbcm_pkg::MAX_NODE_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // input items
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    operation,
  input  logic [10:0]                   can_id,
  input  logic [7:0]                    status_byte,
  input  logic [hbcm_pkg::NODE_W-1:0]   node_id,
  input  logic [hbcm_pkg::HB_W-1:0]     heartbeat_ms,
  // result items
  output logic                          out_valid,
  input  logic                          out_ready,
  output hbcm_pkg::res_t                out_res,
  // table memory
  output logic                          ram_we,
  output logic [hbcm_pkg::IDX_W-1:0]    ram_waddr,
  output logic [hbcm_pkg::ENTRY_W-1:0]  ram_wdata,
  output logic                          ram_re,
  output logic [hbcm_pkg::IDX_W-1:0]    ram_raddr,
  input  logic [hbcm_pkg::ENTRY_W-1:0]  ram_rdata,
  // reload unit
  output logic                          rl_start,
  output logic [hbcm_pkg::HB_W-1:0]     rl_ms,
  input  logic                          rl_done,
  input  logic [hbcm_pkg::CD_W-1:0]     rl_value
);

  localparam logic [hbcm_pkg::NODE_W-1:0] MAX_N = hbcm_pkg::NODE_W'(MAX_NODE);

  hbcm_pkg::fsm_t                state, state_next;
  logic [1:0]                    op_q, op_q_next;
  logic [hbcm_pkg::NODE_W-1:0]   node_q, node_q_next;
  logic [6:0]                    data_q, data_q_next;
  logic [hbcm_pkg::HB_W-1:0]     ms_q, ms_q_next;
  logic [hbcm_pkg::IDX_W-1:0]    addr_q, addr_q_next;
  hbcm_pkg::entry_t              work, work_next;
  hbcm_pkg::res_t                res, res_next;
  logic [hbcm_pkg::NODE_W-1:0]   idx, idx_next;
  logic                          pend_valid, pend_valid_next;
  logic [hbcm_pkg::NODE_W-1:0]   pend_node, pend_node_next;
  logic [hbcm_pkg::DEPTH-1:0]    vld, vld_next;
  hbcm_pkg::res_t                out_res_next;
  logic                          out_valid_next;

  hbcm_pkg::entry_t              rd_entry;
  hbcm_pkg::entry_t              tick_entry;
  hbcm_pkg::res_t                emit_res;
  logic                          emit;
  logic                          slot_free;
  logic                          frame_ok;
  logic                          need_emit;
  logic                          active;
  logic                          hit;
  logic [hbcm_pkg::CD_W-1:0]     dec;

  function automatic logic node_ok(input logic [hbcm_pkg::NODE_W-1:0] n);
    return (n != '0) && (n <= MAX_N);
  endfunction

  // entries never written read as their reset contents
  always_comb begin
    rd_entry = vld[addr_q] ? hbcm_pkg::entry_t'(ram_rdata) : hbcm_pkg::entry_reset(addr_q);
  end

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == hbcm_pkg::S_IDLE);
  assign frame_ok  = (can_id[10:8] == hbcm_pkg::HB_ID_BASE_HI) && !can_id[7]
                     && node_ok(can_id[6:0]);
  assign need_emit = (op_q == hbcm_pkg::OP_SET) || (data_q == 7'd0);

  // tick step on the entry under the scan
  always_comb begin
    active     = (rd_entry.hb != '0) && (rd_entry.cd != '0);
    dec        = rd_entry.cd - hbcm_pkg::CD_W'(1);
    hit        = active && (dec == '0);
    tick_entry.state = hit ? hbcm_pkg::ST_UNCERTAIN : rd_entry.state;
    tick_entry.hb    = rd_entry.hb;
    tick_entry.cd    = dec;
  end

  // next state and outputs
  always_comb begin
    state_next      = state;
    op_q_next       = op_q;
    node_q_next     = node_q;
    data_q_next     = data_q;
    ms_q_next       = ms_q;
    addr_q_next     = addr_q;
    work_next       = work;
    res_next        = res;
    idx_next        = idx;
    pend_valid_next = pend_valid;
    pend_node_next  = pend_node;
    vld_next        = vld;
    ram_re          = 1'b0;
    ram_raddr       = addr_q;
    ram_we          = 1'b0;
    ram_waddr       = addr_q;
    ram_wdata       = work;
    rl_start        = 1'b0;
    rl_ms           = ms_q;
    emit            = 1'b0;
    emit_res        = res;

    case (state)
      hbcm_pkg::S_IDLE: begin
        if (in_valid) begin
          op_q_next   = operation;
          data_q_next = status_byte[6:0];
          ms_q_next   = heartbeat_ms;
          case (operation)
            hbcm_pkg::OP_FRAME: begin
              node_q_next = can_id[6:0];
              if (frame_ok) begin
                ram_re      = 1'b1;
                ram_raddr   = can_id[hbcm_pkg::IDX_W-1:0];
                addr_q_next = can_id[hbcm_pkg::IDX_W-1:0];
                state_next  = hbcm_pkg::S_LOOK;
              end
            end
            hbcm_pkg::OP_TICK: begin
              idx_next        = hbcm_pkg::NODE_W'(1);
              pend_valid_next = 1'b0;
              state_next      = hbcm_pkg::S_TRD;
            end
            hbcm_pkg::OP_SET: begin
              node_q_next = node_id;
              if (node_ok(node_id)) begin
                ram_re      = 1'b1;
                ram_raddr   = node_id[hbcm_pkg::IDX_W-1:0];
                addr_q_next = node_id[hbcm_pkg::IDX_W-1:0];
                state_next  = hbcm_pkg::S_LOOK;
              end else begin
                res_next   = '{kind: hbcm_pkg::KIND_SET, node: node_id, state: '0,
                               ms: '0, error: 1'b1, last: 1'b1};
                state_next = hbcm_pkg::S_EMIT;
              end
            end
            hbcm_pkg::OP_READ: begin
              node_q_next = node_id;
              if (node_id <= MAX_N) begin
                ram_re      = 1'b1;
                ram_raddr   = node_id[hbcm_pkg::IDX_W-1:0];
                addr_q_next = node_id[hbcm_pkg::IDX_W-1:0];
                state_next  = hbcm_pkg::S_LOOK;
              end else begin
                res_next   = '{kind: hbcm_pkg::KIND_READ, node: node_id,
                               state: hbcm_pkg::ST_UNKNOWN, ms: '0, error: 1'b1,
                               last: 1'b1};
                state_next = hbcm_pkg::S_EMIT;
              end
            end
            default: begin
              state_next = hbcm_pkg::S_IDLE;
            end
          endcase
        end
      end

      // entry data is here: decide the update
      hbcm_pkg::S_LOOK: begin
        work_next = rd_entry;
        case (op_q)
          hbcm_pkg::OP_FRAME: begin
            work_next.state = {1'b0, data_q};
            if (rd_entry.hb != '0) begin
              rl_start   = 1'b1;
              rl_ms      = rd_entry.hb;
              state_next = hbcm_pkg::S_DIV;
            end else begin
              state_next = hbcm_pkg::S_WB;
            end
          end
          hbcm_pkg::OP_SET: begin
            work_next.hb = ms_q;
            if (ms_q == '0) begin
              work_next.state = hbcm_pkg::ST_UNKNOWN;
              work_next.cd    = hbcm_pkg::CD_ONES;
              state_next      = hbcm_pkg::S_WB;
            end else begin
              rl_start   = 1'b1;
              rl_ms      = ms_q;
              state_next = hbcm_pkg::S_DIV;
            end
          end
          default: begin
            // read: node zero reports the master state with an error
            res_next   = '{kind: hbcm_pkg::KIND_READ, node: node_q, state: rd_entry.state,
                           ms: (node_q != '0) ? rd_entry.hb : '0,
                           error: (node_q == '0), last: 1'b1};
            state_next = hbcm_pkg::S_EMIT;
          end
        endcase
      end

      // wait for the reload value
      hbcm_pkg::S_DIV: begin
        if (rl_done) begin
          work_next.cd = rl_value;
          state_next   = hbcm_pkg::S_WB;
        end
      end

      // write back, with the reply if there is one
      hbcm_pkg::S_WB: begin
        if (!need_emit || slot_free) begin
          ram_we           = 1'b1;
          vld_next[addr_q] = 1'b1;
          if (need_emit) begin
            emit     = 1'b1;
            emit_res = '{kind: (op_q == hbcm_pkg::OP_SET) ? hbcm_pkg::KIND_SET
                                                           : hbcm_pkg::KIND_BOOT,
                         node: node_q, state: work.state, ms: '0, error: 1'b0,
                         last: 1'b1};
          end
          state_next = hbcm_pkg::S_IDLE;
        end
      end

      hbcm_pkg::S_EMIT: begin
        if (slot_free) begin
          emit       = 1'b1;
          emit_res   = res;
          state_next = hbcm_pkg::S_IDLE;
        end
      end

      // tick scan: read the next node
      hbcm_pkg::S_TRD: begin
        if (idx > MAX_N) begin
          state_next = hbcm_pkg::S_TEND;
        end else begin
          ram_re      = 1'b1;
          ram_raddr   = idx[hbcm_pkg::IDX_W-1:0];
          addr_q_next = idx[hbcm_pkg::IDX_W-1:0];
          state_next  = hbcm_pkg::S_TMOD;
        end
      end

      // tick scan: count down; a warning is held until the next one shows
      hbcm_pkg::S_TMOD: begin
        if (!(hit && pend_valid && !slot_free)) begin
          if (active) begin
            ram_we           = 1'b1;
            ram_wdata        = tick_entry;
            vld_next[addr_q] = 1'b1;
          end
          if (hit) begin
            if (pend_valid) begin
              emit     = 1'b1;
              emit_res = '{kind: hbcm_pkg::KIND_WARN, node: pend_node,
                           state: hbcm_pkg::ST_UNCERTAIN, ms: '0, error: 1'b0,
                           last: 1'b0};
            end
            pend_node_next  = idx;
            pend_valid_next = 1'b1;
          end
          idx_next   = idx + hbcm_pkg::NODE_W'(1);
          state_next = hbcm_pkg::S_TRD;
        end
      end

      // tick scan done: the held warning is the final item
      hbcm_pkg::S_TEND: begin
        if (!pend_valid) begin
          state_next = hbcm_pkg::S_IDLE;
        end else if (slot_free) begin
          emit            = 1'b1;
          emit_res        = '{kind: hbcm_pkg::KIND_WARN, node: pend_node,
                              state: hbcm_pkg::ST_UNCERTAIN, ms: '0, error: 1'b0,
                              last: 1'b1};
          pend_valid_next = 1'b0;
          state_next      = hbcm_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = hbcm_pkg::S_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_res_next   = out_res;
    out_valid_next = out_valid;
    if (emit) begin
      out_res_next   = emit_res;
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= hbcm_pkg::S_IDLE;
      pend_valid <= 1'b0;
      vld        <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      pend_valid <= pend_valid_next;
      vld        <= vld_next;
      out_valid  <= out_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_q      <= op_q_next;
    node_q    <= node_q_next;
    data_q    <= data_q_next;
    ms_q      <= ms_q_next;
    addr_q    <= addr_q_next;
    work      <= work_next;
    res       <= res_next;
    idx       <= idx_next;
    pend_node <= pend_node_next;
    out_res   <= out_res_next;
  end

endmodule

>>> hdl/heartbeat_consumer_monitor_unit.sv
// top level of the heartbeat consumer monitor
//
// Keeps state code, heartbeat time and tick countdown of nodes 1..MAX_NODE in one
// 64-entry table ram; one item is worked at a time. A set or frame that reloads the
// countdown waits on the bit-serial reload divider (26 quotient bits, one per cycle);
// a read, a set to an invalid node, a set with zero time, a frame from an unmonitored
// node and a foreign frame do not use it. A timer tick walks the table node by node,
// reading each entry and writing it back when its countdown runs. A full result
// register that is not taken stalls the item. Entries reset through per-entry valid
// bits, so the block takes items right after reset with no clearing pass. The tick
// period register may be written only while the block is idle.
module heartbeat_consumer_monitor_unit #(
  parameter int MAX_NODE = hbcm_pkg::MAX_NODE_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [hbcm_pkg::PERIOD_W-1:0] tick_period_us,
  // input items
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    operation,
  input  logic [10:0]                   can_id,
  input  logic [7:0]                    status_byte,
  input  logic [hbcm_pkg::NODE_W-1:0]   node_id,
  input  logic [hbcm_pkg::HB_W-1:0]     heartbeat_ms,
  // result items
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    kind,
  output logic [hbcm_pkg::NODE_W-1:0]   event_node,
  output logic [hbcm_pkg::ST_W-1:0]     node_state_out,
  output logic [hbcm_pkg::HB_W-1:0]     heartbeat_ms_out,
  output logic                          error,
  output logic                          last
);

  logic [hbcm_pkg::PERIOD_W-1:0] period;
  hbcm_pkg::res_t                out_res;
  logic                          ram_we;
  logic [hbcm_pkg::IDX_W-1:0]    ram_waddr;
  logic [hbcm_pkg::ENTRY_W-1:0]  ram_wdata;
  logic                          ram_re;
  logic [hbcm_pkg::IDX_W-1:0]    ram_raddr;
  logic [hbcm_pkg::ENTRY_W-1:0]  ram_rdata;
  logic                          rl_start;
  logic [hbcm_pkg::HB_W-1:0]     rl_ms;
  logic                          rl_done;
  logic [hbcm_pkg::CD_W-1:0]     rl_value;

  // tick period register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      period <= hbcm_pkg::PERIOD_RESET;
    end else if (cfg_valid) begin
      period <= tick_period_us;
    end
  end

  // node table
  hbcm_ram #(
    .WIDTH (hbcm_pkg::ENTRY_W),
    .DEPTH (hbcm_pkg::DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // countdown reload divider
  hbcm_reload u_reload (
    .clk    (clk),
    .rst    (rst),
    .start  (rl_start),
    .ms     (rl_ms),
    .period (period),
    .done   (rl_done),
    .value  (rl_value)
  );

  // sequencer
  hbcm_ctrl #(
    .MAX_NODE (MAX_NODE)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .can_id       (can_id),
    .status_byte  (status_byte),
    .node_id      (node_id),
    .heartbeat_ms (heartbeat_ms),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_res      (out_res),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_re       (ram_re),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata),
    .rl_start     (rl_start),
    .rl_ms        (rl_ms),
    .rl_done      (rl_done),
    .rl_value     (rl_value)
  );

  // result fields
  assign kind             = out_res.kind;
  assign event_node       = out_res.node;
  assign node_state_out   = out_res.state;
  assign heartbeat_ms_out = out_res.ms;
  assign error            = out_res.error;
  assign last             = out_res.last;

endmodule

>>> hdl/hbcm_checker.sv
// port-level checks on the heartbeat consumer monitor and their binding
module hbcm_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [1:0]                  kind,
  input logic [hbcm_pkg::NODE_W-1:0] event_node,
  input logic [hbcm_pkg::ST_W-1:0]   node_state_out,
  input logic [hbcm_pkg::HB_W-1:0]   heartbeat_ms_out,
  input logic                        error,
  input logic                        last
);

  // a stalled item holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(event_node)
      && $stable(node_state_out) && $stable(heartbeat_ms_out) && $stable(error)
      && $stable(last))
    else $error("result item changed while stalled");

  // only a tick gives more than one item
  a_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != hbcm_pkg::KIND_WARN |-> last)
    else $error("non-tick item without last");

  // warnings carry the uncertain state
  a_warn: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == hbcm_pkg::KIND_WARN |->
      node_state_out == hbcm_pkg::ST_UNCERTAIN && heartbeat_ms_out == '0 && !error)
    else $error("malformed heartbeat lost warning");

  // bootup events carry state zero
  a_boot: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == hbcm_pkg::KIND_BOOT |->
      node_state_out == hbcm_pkg::ST_BOOT && heartbeat_ms_out == '0 && !error)
    else $error("malformed bootup event");

  // errors only come with set or read replies
  a_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> kind == hbcm_pkg::KIND_SET || kind == hbcm_pkg::KIND_READ)
    else $error("error flag on an event item");

endmodule

bind heartbeat_consumer_monitor_unit hbcm_checker u_hbcm_checker (.*);
